@@ src/unp_pkg.sv @@
// ----------------------------------------------------------------------------
// unp_pkg: shared constants, types and helpers for the ambient noise core
// Fixed-point widths, Q30 scale factors, register indexes and the rounding
// multiply used by the log10 and dB conversion stages.
// ----------------------------------------------------------------------------
package unp_pkg;

   // Field widths
   localparam int FREQ_FRAC_BITS_DEF = 8;
   localparam int FREQ_W             = 24;
   localparam int NOISE_W            = 17;
   localparam int WIND_W             = 16;
   localparam int SHIP_W             = 9;
   localparam int CSR_W              = 16;
   localparam int CSR_IDX_W          = 1;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_WIND_SPEED = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SHIP_ACT   = 1'b1;

   localparam logic [WIND_W-1:0] WIND_RESET = 16'd256;
   localparam logic [SHIP_W-1:0] SHIP_RESET = 9'd0;

   // Internal number formats
   localparam int FRAC_W  = 16;          // Q16 fraction of logs and exponents
   localparam int LOG_W   = 24;          // signed Q8.16 log value
   localparam int RND_W   = LOG_W + 3;   // result of the Q30 rounding multiply
   localparam int TERM_W  = 32;          // signed Q16 dB terms
   localparam int MANT_W  = 31;          // Q30 mantissa / power ratio
   localparam int E_W     = 32;          // Q16 exponent of a power ratio
   localparam int SUM_W   = MANT_W + 2;  // sum of four ratios

   // Pipeline depth of the shared units
   localparam int LOG_LAT = FRAC_W + 2;
   localparam int POW_LAT = FRAC_W + 1;

   // Q30 / Q32 scale factors
   localparam logic [28:0] LOG10_2_Q30       = 29'd323228497;
   localparam logic [31:0] DB10_2_Q30        = 32'd3232284966;
   localparam logic [28:0] LOG2_10_DIV10_Q30 = 29'd356689313;
   localparam logic [31:0] OFF_003_Q32       = 32'd128849019;
   localparam logic [31:0] OFF_04_Q32        = 32'd1717986918;

   typedef logic signed [LOG_W-1:0] log_type;

   // a * b / 2^30, rounded half away from zero
   function automatic logic signed [RND_W-1:0] mul_rnd_q30(input log_type a,
                                                           input logic [31:0] b);
      logic [LOG_W-1:0]         mag;
      logic [LOG_W+31:0]        prod;
      logic signed [RND_W-1:0]  rv;
      mag  = a[LOG_W-1] ? LOG_W'(-a) : LOG_W'(a);
      prod = (LOG_W+32)'(mag) * (LOG_W+32)'(b) + (LOG_W+32)'(64'd1 << 29);
      rv   = {1'b0, prod[LOG_W+31:30]};
      return a[LOG_W-1] ? -rv : rv;
   endfunction

   // Truncated integer square root, elaboration only
   function automatic logic [63:0] isqrt_const(input logic [63:0] x_in);
      logic [63:0] x;
      logic [63:0] res;
      logic [63:0] bitv;
      x    = x_in;
      res  = '0;
      bitv = 64'h4000_0000_0000_0000;
      for (int i = 0; i < 32; i++) begin
         if (x >= res + bitv) begin
            x   = x - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   // 2^(-2^(k-16)) in Q30 from the square-root chain of one half
   function automatic logic [MANT_W-1:0] pow2_coef(input int k);
      logic [63:0] c;
      c = 64'd1 << 29;
      for (int j = FRAC_W - 1; j >= 0; j--) begin
         if (j >= k) begin
            c = isqrt_const(c << 30);
         end
      end
      return c[MANT_W-1:0];
   endfunction

endpackage

@@ src/unp_delay.sv @@
// ----------------------------------------------------------------------------
// unp_delay: stalling delay line
// Carries side data alongside the pipeline, one register per stage.
// ----------------------------------------------------------------------------
module unp_delay #(
   parameter int W     = 1,
   parameter int DEPTH = 2
) (
   input  logic         clock,
   input  logic         en,
   input  logic [W-1:0] din,
   output logic [W-1:0] dout
);

   logic [W-1:0] d_ff [DEPTH];

   // Advance the line on every pipeline step
   always_ff @(posedge clock) begin
      if (en) begin
         d_ff[0] <= din;
         for (int i = 1; i < DEPTH; i++) begin
            d_ff[i] <= d_ff[i-1];
         end
      end
   end

   assign dout = d_ff[DEPTH-1];

endmodule

@@ src/unp_sqrt.sv @@
// ----------------------------------------------------------------------------
// unp_sqrt: pipelined integer square root of the wind speed
// Takes sqrt(wind << 24) one result bit per stage; the result reads as Q16.
// ----------------------------------------------------------------------------
module unp_sqrt (
   input  logic                        clock,
   input  logic                        en,
   input  logic [unp_pkg::WIND_W-1:0]  wind,
   output logic [(unp_pkg::WIND_W+24)/2-1:0] root
);

   localparam int RAD_W  = unp_pkg::WIND_W + 24;
   localparam int ROOT_W = RAD_W / 2;
   localparam int REM_W  = ROOT_W + 2;

   logic [unp_pkg::WIND_W-1:0] w_ff [ROOT_W];
   logic [REM_W-1:0]           rem_ff [ROOT_W];
   logic [ROOT_W-1:0]          q_ff [ROOT_W];

   for (genvar j = 0; j < ROOT_W; j++) begin : g_step
      logic [unp_pkg::WIND_W-1:0] w_cur;
      logic [REM_W-1:0]           rem_cur;
      logic [ROOT_W-1:0]          q_cur;
      logic [RAD_W-1:0]           rad;
      logic [REM_W+1:0]           rem_sh;
      logic [REM_W+1:0]           trial;
      logic                       ge;

      if (j == 0) begin : g_first
         assign w_cur   = wind;
         assign rem_cur = '0;
         assign q_cur   = '0;
      end else begin : g_next
         assign w_cur   = w_ff[j-1];
         assign rem_cur = rem_ff[j-1];
         assign q_cur   = q_ff[j-1];
      end

      // Bring down two radicand bits and try the next root bit
      always_comb begin
         rad    = {w_cur, 24'b0};
         rem_sh = {rem_cur, rad[2*(ROOT_W-1-j)+1 -: 2]};
         trial  = (REM_W+2)'({q_cur, 2'b01});
         ge     = rem_sh >= trial;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            w_ff[j]   <= w_cur;
            rem_ff[j] <= ge ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
            q_ff[j]   <= {q_cur[ROOT_W-2:0], ge};
         end
      end
   end

   assign root = q_ff[ROOT_W-1];

endmodule

@@ src/unp_log2.sv @@
// ----------------------------------------------------------------------------
// unp_log2: pipelined base-2 logarithm in Q16
// Finds the leading one, normalizes to a Q30 mantissa and takes one fraction
// bit per stage by squaring.
// ----------------------------------------------------------------------------
module unp_log2 #(
   parameter int IN_W  = 53,
   parameter int SCALE = 32
) (
   input  logic                 clock,
   input  logic                 en,
   input  logic [IN_W-1:0]      x,
   output unp_pkg::log_type     log_q16
);

   localparam int N_W    = $clog2(IN_W);
   localparam int STEPS  = unp_pkg::FRAC_W;
   localparam int MW     = unp_pkg::MANT_W;
   localparam int HI_W   = unp_pkg::LOG_W - unp_pkg::FRAC_W;

   logic [N_W-1:0]  lz_n_in;
   logic [N_W-1:0]  lz_n_ff;
   logic [IN_W-1:0] lz_x_ff;
   logic [IN_W+MW-1:0] wide;
   logic [MW-1:0]   nm_m_in;

   logic [MW-1:0]    m_ff  [STEPS+1];
   logic [STEPS-1:0] fr_ff [STEPS+1];
   logic [N_W-1:0]   n_ff  [STEPS+1];

   logic [HI_W-1:0]  hi;

   // Locate the leading one
   always_comb begin
      lz_n_in = '0;
      for (int i = 0; i < IN_W; i++) begin
         if (x[i]) begin
            lz_n_in = N_W'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lz_n_ff <= lz_n_in;
         lz_x_ff <= x;
      end
   end

   // Normalize to a Q30 mantissa
   always_comb begin
      wide = (IN_W+MW)'(lz_x_ff);
      if (lz_n_ff >= N_W'(30)) begin
         nm_m_in = MW'(wide >> (lz_n_ff - N_W'(30)));
      end else begin
         nm_m_in = MW'(wide << (N_W'(30) - lz_n_ff));
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m_ff[0]  <= nm_m_in;
         fr_ff[0] <= '0;
         n_ff[0]  <= lz_n_ff;
      end
   end

   // Square and take one fraction bit per stage
   for (genvar j = 0; j < STEPS; j++) begin : g_sq
      logic [2*MW-1:0] prod;
      logic [MW:0]     sq;

      always_comb begin
         prod = (2*MW)'(m_ff[j]) * (2*MW)'(m_ff[j]);
         sq   = prod[2*MW-1:30];
      end

      always_ff @(posedge clock) begin
         if (en) begin
            m_ff[j+1]  <= sq[MW] ? sq[MW:1] : sq[MW-1:0];
            fr_ff[j+1] <= {fr_ff[j][STEPS-2:0], sq[MW]};
            n_ff[j+1]  <= n_ff[j];
         end
      end
   end

   // Integer part is the leading-one position less the scale
   always_comb begin
      hi = HI_W'(n_ff[STEPS]) - HI_W'(SCALE);
   end

   assign log_q16 = unp_pkg::log_type'({hi, fr_ff[STEPS]});

endmodule

@@ src/unp_pow2.sv @@
// ----------------------------------------------------------------------------
// unp_pow2: pipelined power ratio 2^(-e) in Q30
// One rounded constant multiply per fraction bit, then the integer shift.
// ----------------------------------------------------------------------------
module unp_pow2 (
   input  logic                        clock,
   input  logic                        en,
   input  logic [unp_pkg::E_W-1:0]     e,
   output logic [unp_pkg::MANT_W-1:0]  ratio
);

   localparam int STEPS = unp_pkg::FRAC_W;
   localparam int MW    = unp_pkg::MANT_W;
   localparam int IP_W  = unp_pkg::E_W - STEPS;

   logic [MW-1:0]            r_ff [STEPS];
   logic [unp_pkg::E_W-1:0]  e_ff [STEPS];
   logic [MW-1:0]            ratio_ff;
   logic [IP_W-1:0]          ip;

   for (genvar j = 0; j < STEPS; j++) begin : g_mul
      localparam logic [MW-1:0] COEF = unp_pkg::pow2_coef(STEPS - 1 - j);
      logic [MW-1:0]           r_cur;
      logic [unp_pkg::E_W-1:0] e_cur;
      logic [2*MW-2:0]         prod;

      if (j == 0) begin : g_first
         assign r_cur = MW'(64'd1 << 30);
         assign e_cur = e;
      end else begin : g_next
         assign r_cur = r_ff[j-1];
         assign e_cur = e_ff[j-1];
      end

      // Multiply in this bit's factor, rounded to nearest
      always_comb begin
         prod = (2*MW-1)'(r_cur) * (2*MW-1)'(COEF) + (2*MW-1)'(64'd1 << 29);
      end

      always_ff @(posedge clock) begin
         if (en) begin
            r_ff[j] <= e_cur[STEPS-1-j] ? prod[2*MW-2:30] : r_cur;
            e_ff[j] <= e_cur;
         end
      end
   end

   // Apply the integer part; drop to zero from 31 on
   always_comb begin
      ip = e_ff[STEPS-1][unp_pkg::E_W-1:STEPS];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ratio_ff <= (ip >= IP_W'(31)) ? '0 : (r_ff[STEPS-1] >> ip[4:0]);
      end
   end

   assign ratio = ratio_ff;

endmodule

@@ src/underwater_noise_psd_core.sv @@
// Throughput: one word per cycle while the skid entry is free; the depth is set
// by the two 18-stage log2 squaring chains and the 17-stage power-ratio multiply chain.
// A two-entry output (register plus skid) lets one more word leave the pipe
// after rsp_ready drops. Reset clears all valid bits and loads the register
// defaults (wind 1.0 m/s, shipping 0); no clearing pass is needed.
// ----------------------------------------------------------------------------
// underwater_noise_psd_core: ambient underwater noise spectral level
// Sums turbulence, shipping, wind and thermal terms as powers and returns
// the total level in dB re 1 uPa per Hz, signed Q9.8, saturated.
// ----------------------------------------------------------------------------
module underwater_noise_psd_core #(
   parameter int FREQ_FRAC_BITS = unp_pkg::FREQ_FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [unp_pkg::FREQ_W-1:0]        req_freq_khz,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [unp_pkg::NOISE_W-1:0] rsp_noise_db,
   output logic                              rsp_invalid,
   input  logic                              csr_wr_en,
   input  logic [unp_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [unp_pkg::CSR_W-1:0]         csr_wdata
);

   localparam int XW      = unp_pkg::FREQ_W + 32 - FREQ_FRAC_BITS + 1;
   localparam int TW      = unp_pkg::TERM_W;
   localparam int OW      = TW + 2;
   localparam int ST_L10  = unp_pkg::LOG_LAT + 1;
   localparam int ST_TERM = ST_L10 + 1;
   localparam int ST_MAX  = ST_TERM + 1;
   localparam int ST_EXP  = ST_MAX + 1;
   localparam int ST_SUM  = ST_EXP + unp_pkg::POW_LAT + 1;
   localparam int ST_DB   = ST_SUM + unp_pkg::LOG_LAT + 1;
   localparam int ST_OUT  = ST_DB + 1;
   localparam int N_STG   = ST_OUT + 1;
   localparam int ROOT_W  = (unp_pkg::WIND_W + 24) / 2;

   // Configuration registers
   logic [unp_pkg::WIND_W-1:0] wind_ff;
   logic [unp_pkg::SHIP_W-1:0] ship_ff;

   // Pipeline control
   logic             en;
   logic [N_STG-1:0] v_ff;

   // Front end
   logic [XW-1:0] x1_in, x3_in, x4_in;
   logic [XW-1:0] x1_ff, x3_ff, x4_ff;
   unp_pkg::log_type log1, log3, log4;
   unp_pkg::log_type l1_ff, l3_ff, l4_ff;
   logic [ROOT_W-1:0] sq;

   // Terms and power sum
   logic signed [TW-1:0] t_in [4];
   logic signed [TW-1:0] t_ff [4];
   logic signed [TW-1:0] tm_ff [4];
   logic signed [TW-1:0] mx_in, mx_ff;
   logic [unp_pkg::E_W-1:0]    e_ff [4];
   logic [unp_pkg::MANT_W-1:0] ratio [4];
   logic [unp_pkg::SUM_W-1:0]  sum_ff;
   unp_pkg::log_type           logs;
   logic signed [unp_pkg::RND_W-1:0] db_ff;

   // Back end
   logic signed [TW-1:0] mx_d;
   logic                 zero_in, zero_d;
   logic signed [OW-1:0] tot, q;
   logic [OW-1:0]        mag, qm;
   logic signed [unp_pkg::NOISE_W-1:0] noise_in, noise_ff, sk_noise_ff;
   logic                 inv_in, inv_ff, sk_inv_ff;
   logic                 sk_v_ff, sk_v_in;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         wind_ff <= unp_pkg::WIND_RESET;
         ship_ff <= unp_pkg::SHIP_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            unp_pkg::CSR_WIND_SPEED: wind_ff <= csr_wdata;
            unp_pkg::CSR_SHIP_ACT:   ship_ff <= csr_wdata[unp_pkg::SHIP_W-1:0];
            default: ;
         endcase
      end
   end

   // Advance whenever the skid entry is free
   assign en        = !sk_v_ff;
   assign req_ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[N_STG-2:0], req_valid};
      end
   end

   // Scale frequency to Q32 and add the offsets
   always_comb begin
      x1_in   = XW'(req_freq_khz) << (32 - FREQ_FRAC_BITS);
      x3_in   = x1_in + XW'(unp_pkg::OFF_003_Q32);
      x4_in   = x1_in + XW'(unp_pkg::OFF_04_Q32);
      zero_in = req_freq_khz == '0;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x1_ff <= x1_in;
         x3_ff <= x3_in;
         x4_ff <= x4_in;
      end
   end

   unp_log2 #(.IN_W(XW), .SCALE(32)) u_log_f (
      .clock(clock), .en(en), .x(x1_ff), .log_q16(log1));
   unp_log2 #(.IN_W(XW), .SCALE(32)) u_log_f3 (
      .clock(clock), .en(en), .x(x3_ff), .log_q16(log3));
   unp_log2 #(.IN_W(XW), .SCALE(32)) u_log_f4 (
      .clock(clock), .en(en), .x(x4_ff), .log_q16(log4));

   unp_sqrt u_sqrt (.clock(clock), .en(en), .wind(wind_ff), .root(sq));

   // Convert to log10
   always_ff @(posedge clock) begin
      if (en) begin
         l1_ff <= unp_pkg::log_type'(unp_pkg::mul_rnd_q30(log1, 32'(unp_pkg::LOG10_2_Q30)));
         l3_ff <= unp_pkg::log_type'(unp_pkg::mul_rnd_q30(log3, 32'(unp_pkg::LOG10_2_Q30)));
         l4_ff <= unp_pkg::log_type'(unp_pkg::mul_rnd_q30(log4, 32'(unp_pkg::LOG10_2_Q30)));
      end
   end

   // Form the four dB terms
   always_comb begin
      logic signed [TW-1:0] l1x, l3x, l4x, shipx, windx;
      l1x   = TW'(l1_ff);
      l3x   = TW'(l3_ff);
      l4x   = TW'(l4_ff);
      shipx = TW'(signed'({1'b0, ship_ff})) - 32'sd128;
      windx = signed'(TW'((24'(sq) * 24'd15) >> 1));
      t_in[0] = 32'sd1114112 - 32'sd30 * l1x;                       // turbulence
      t_in[1] = 32'sd2621440 + shipx * 32'sd5120
              + 32'sd26 * l1x - 32'sd60 * l3x;                       // shipping
      t_in[2] = 32'sd3276800 + windx + 32'sd20 * l1x - 32'sd40 * l4x; // wind
      t_in[3] = -32'sd983040 + 32'sd20 * l1x;                        // thermal
   end

   always_ff @(posedge clock) begin
      if (en) begin
         t_ff <= t_in;
      end
   end

   // Pick the largest term
   always_comb begin
      mx_in = t_ff[0];
      for (int i = 1; i < 4; i++) begin
         if (t_ff[i] > mx_in) begin
            mx_in = t_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mx_ff <= mx_in;
         tm_ff <= t_ff;
      end
   end

   // Exponent of each ratio: (max - term) * log2(10) / 10
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 4; i++) begin
            e_ff[i] <= unp_pkg::E_W'(((64'(unsigned'(mx_ff - tm_ff[i]))
                        * 64'(unp_pkg::LOG2_10_DIV10_Q30)) + (64'd1 << 29)) >> 30);
         end
      end
   end

   for (genvar i = 0; i < 4; i++) begin : g_pow
      unp_pow2 u_pow (.clock(clock), .en(en), .e(e_ff[i]), .ratio(ratio[i]));
   end

   // Sum the power ratios
   always_ff @(posedge clock) begin
      if (en) begin
         sum_ff <= unp_pkg::SUM_W'(ratio[0]) + unp_pkg::SUM_W'(ratio[1])
                 + unp_pkg::SUM_W'(ratio[2]) + unp_pkg::SUM_W'(ratio[3]);
      end
   end

   unp_log2 #(.IN_W(unp_pkg::SUM_W), .SCALE(30)) u_log_sum (
      .clock(clock), .en(en), .x(sum_ff), .log_q16(logs));

   // Back to dB
   always_ff @(posedge clock) begin
      if (en) begin
         db_ff <= unp_pkg::mul_rnd_q30(logs, unp_pkg::DB10_2_Q30);
      end
   end

   unp_delay #(.W(TW), .DEPTH(ST_DB - ST_MAX)) u_dly_max (
      .clock(clock), .en(en), .din(mx_ff), .dout(mx_d));
   unp_delay #(.W(1), .DEPTH(ST_DB + 1)) u_dly_zero (
      .clock(clock), .en(en), .din(zero_in), .dout(zero_d));

   // Add the largest term, round to Q8 and saturate; a zero frequency gives zero, flagged invalid
   always_comb begin
      tot = OW'(mx_d) + OW'(db_ff);
      mag = tot[OW-1] ? OW'(-tot) : OW'(tot);
      qm  = (mag + OW'(128)) >> 8;
      q   = tot[OW-1] ? -signed'(qm) : signed'(qm);
      if (zero_d) begin
         noise_in = '0;
         inv_in   = 1'b1;
      end else if (q > OW'(65535)) begin
         noise_in = 17'sh0FFFF;
         inv_in   = 1'b1;
      end else if (q < -OW'(65536)) begin
         noise_in = 17'sh10000;
         inv_in   = 1'b1;
      end else begin
         noise_in = unp_pkg::NOISE_W'(q);
         inv_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         noise_ff <= noise_in;
         inv_ff   <= inv_in;
      end
   end

   // Park the last word when the consumer stalls
   always_comb begin
      if (sk_v_ff) begin
         sk_v_in = !rsp_ready;
      end else begin
         sk_v_in = v_ff[ST_OUT] && !rsp_ready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sk_v_ff <= 1'b0;
      end else begin
         sk_v_ff <= sk_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!sk_v_ff) begin
         sk_noise_ff <= noise_ff;
         sk_inv_ff   <= inv_ff;
      end
   end

   assign rsp_valid    = sk_v_ff || v_ff[ST_OUT];
   assign rsp_noise_db = sk_v_ff ? sk_noise_ff : noise_ff;
   assign rsp_invalid  = sk_v_ff ? sk_inv_ff : inv_ff;

   // The largest term always contributes a full ratio of one
   a_sum_floor: assert property (@(posedge clock) disable iff (reset)
      v_ff[ST_SUM] |-> (sum_ff >= unp_pkg::SUM_W'(64'd1 << 30)))
      else $error("power sum below one");

   // A held pipeline keeps its valid bits
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(v_ff))
      else $error("valid bits moved during stall");

   // The skid entry fills only from a stalled output word
   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      $rose(sk_v_ff) |-> $past(v_ff[ST_OUT] && !rsp_ready))
      else $error("skid filled without a stalled word");

   // A flagged word is zero or a saturation bound
   a_flag: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_invalid) |-> (rsp_noise_db == 17'sh00000
         || rsp_noise_db == 17'sh0FFFF || rsp_noise_db == 17'sh10000))
      else $error("invalid flag on an in-range level");

endmodule

@@ bench/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the ambient noise spectral level core
// Drives frequency words through the valid/ready request channel, predicts
// each noise level with a bit-exact fixed-point model of the four-term
// power sum, and checks every response word in order. Sweeps wind speed and
// shipping settings, including their extremes.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int FRAC_BITS  = unp_pkg::FREQ_FRAC_BITS_DEF;
   localparam int STALL_MAX  = 2000;
   localparam int DRAIN_CYC  = 80;
   localparam longint unsigned L10_2  = 64'd323228497;
   localparam longint unsigned DB10_2 = 64'd3232284966;
   localparam longint unsigned L2_10  = 64'd356689313;
   localparam longint unsigned OFS003 = 64'd128849019;
   localparam longint unsigned OFS04  = 64'd1717986918;

   typedef struct packed {
      logic signed [unp_pkg::NOISE_W-1:0] noise_db;
      logic                               invalid;
   } level_type;

   logic                                clock;
   logic                                reset;
   logic                                req_valid;
   logic                                req_ready;
   logic [unp_pkg::FREQ_W-1:0]          req_freq_khz;
   logic                                rsp_valid;
   logic                                rsp_ready;
   logic signed [unp_pkg::NOISE_W-1:0]  rsp_noise_db;
   logic                                rsp_invalid;
   logic                                csr_wr_en;
   logic [unp_pkg::CSR_IDX_W-1:0]       csr_index;
   logic [unp_pkg::CSR_W-1:0]           csr_wdata;

   // Model copy of the configuration registers
   logic [unp_pkg::WIND_W-1:0] cur_wind;
   logic [unp_pkg::SHIP_W-1:0] cur_ship;

   level_type level_q[$];
   int     send_idle_pct;
   int     recv_idle_pct;
   int     n_sent;
   int     n_checked;
   int     n_errors;
   int     n_invalid;
   int     n_cfg;
   int     stall_cnt;

   underwater_noise_psd_core DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_freq_khz(req_freq_khz),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_noise_db(rsp_noise_db), .rsp_invalid(rsp_invalid),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Fixed-point noise level model
   // ---------------------------------------------------------------------
   function automatic longint unsigned int_sqrt(input longint unsigned x);
      longint unsigned res;
      longint unsigned bitv;
      res  = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (x >= res + bitv) begin
            x   = x - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   // a * b / 2^sh, rounded half away from zero
   function automatic longint scale_round(input longint a, input longint unsigned b,
                                          input int sh);
      longint unsigned mag;
      longint unsigned p;
      mag = (a < 0) ? longint'(-a) : a;
      p   = (mag * b + (64'd1 << (sh - 1))) >> sh;
      return (a < 0) ? -longint'(p) : longint'(p);
   endfunction

   // log2(x / 2^scale) in Q16 by mantissa squaring
   function automatic longint log2_fix(input longint unsigned x, input int scale);
      int              n;
      longint unsigned m;
      longint          fr;
      n  = 63;
      fr = 0;
      while (x[n] == 1'b0) n--;
      m = (n >= 30) ? (x >> (n - 30)) : (x << (30 - n));
      for (int k = 0; k < 16; k++) begin
         m  = (m * m) >> 30;
         fr = fr << 1;
         if (m >= (64'd1 << 31)) begin
            m  = m >> 1;
            fr = fr | 1;
         end
      end
      return longint'(n - scale) * 65536 + fr;
   endfunction

   // 2^(-e/65536) in Q30
   function automatic longint unsigned pow2_neg(input longint unsigned e);
      longint unsigned ip;
      longint unsigned r;
      longint unsigned c;
      ip = e >> 16;
      r  = 64'd1 << 30;
      c  = 64'd1 << 29;
      if (ip >= 31) return 0;
      for (int k = 15; k >= 0; k--) begin
         c = int_sqrt(c << 30);
         if (e[k]) r = (r * c + (64'd1 << 29)) >> 30;
      end
      return r >> ip;
   endfunction

   function automatic level_type noise_level(input logic [unp_pkg::FREQ_W-1:0] freq);
      level_type       lv;
      longint unsigned x;
      longint unsigned sq;
      longint unsigned sum;
      longint          l1, l3, l4, mx, tot, q;
      longint          term[4];
      lv  = '0;
      sum = 0;
      if (freq == '0) begin
         lv.invalid = 1'b1;
         return lv;
      end
      x  = longint'(freq) << (32 - FRAC_BITS);
      l1 = scale_round(log2_fix(x, 32), L10_2, 30);
      l3 = scale_round(log2_fix(x + OFS003, 32), L10_2, 30);
      l4 = scale_round(log2_fix(x + OFS04, 32), L10_2, 30);
      sq = int_sqrt(longint'(cur_wind) << 24);
      term[0] = 17 * 65536 - 30 * l1;
      term[1] = 40 * 65536 + (longint'(cur_ship) - 128) * 5120 + 26 * l1 - 60 * l3;
      term[2] = 50 * 65536 + longint'((sq * 15) >> 1) + 20 * l1 - 40 * l4;
      term[3] = -15 * 65536 + 20 * l1;
      mx = term[0];
      for (int i = 1; i < 4; i++) if (term[i] > mx) mx = term[i];
      for (int i = 0; i < 4; i++) sum += pow2_neg(scale_round(mx - term[i], L2_10, 30));
      tot = mx + scale_round(log2_fix(sum, 30), DB10_2, 30);
      q   = scale_round(tot, 1, 8);
      if (q > 65535) begin
         q = 65535;
         lv.invalid = 1'b1;
      end else if (q < -65536) begin
         q = -65536;
         lv.invalid = 1'b1;
      end
      lv.noise_db = q[unp_pkg::NOISE_W-1:0];
      return lv;
   endfunction

   // ---------------------------------------------------------------------
   // Shared driving tasks
   // ---------------------------------------------------------------------
   task automatic send_word(input logic [unp_pkg::FREQ_W-1:0] freq);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_freq_khz <= freq;
      do @(posedge clock); while (!req_ready);
      level_q.push_back(noise_level(freq));
      n_sent++;
   endtask

   // Drop valid and let the pipe empty before touching registers
   task automatic drain;
      req_valid <= 1'b0;
      @(posedge clock);
      while (level_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [unp_pkg::CSR_IDX_W-1:0] idx,
                            input logic [unp_pkg::CSR_W-1:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
      if (idx == unp_pkg::CSR_WIND_SPEED) cur_wind = val[unp_pkg::WIND_W-1:0];
      else cur_ship = val[unp_pkg::SHIP_W-1:0];
      n_cfg++;
   endtask

   task automatic set_env(input logic [unp_pkg::WIND_W-1:0] wind,
                          input logic [unp_pkg::SHIP_W-1:0] ship);
      drain();
      write_reg(unp_pkg::CSR_WIND_SPEED, unp_pkg::CSR_W'(wind));
      write_reg(unp_pkg::CSR_SHIP_ACT, unp_pkg::CSR_W'(ship));
   endtask

   function automatic logic [unp_pkg::FREQ_W-1:0] rand_freq;
      int sel;
      sel = $urandom_range(99);
      if (sel < 45) return unp_pkg::FREQ_W'($urandom_range(24'hFFFFFF, 0));
      if (sel < 90) return unp_pkg::FREQ_W'($urandom) >> $urandom_range(23, 0);
      if (sel < 95) return '0;
      return unp_pkg::FREQ_W'($urandom_range(3, 1));
   endfunction

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------
   task automatic test_directed;
      logic [unp_pkg::FREQ_W-1:0] pts[10];
      pts = '{24'h0, 24'h1, 24'hFFFFFF, 24'h100, 24'h800000, 24'h000080,
              24'h00000A, 24'h0003E8, 24'h555555, 24'hAAAAAA};
      // Reset defaults first
      foreach (pts[i]) send_word(pts[i]);
      set_env(16'h0000, 9'd256);
      for (int i = 0; i < 5; i++) send_word(pts[i]);
      set_env(16'hFFFF, 9'd511);
      for (int i = 0; i < 5; i++) send_word(pts[i]);
      set_env(16'h0100, 9'd0);
      send_word(24'h7FFFFF);
      drain();
   endtask

   task automatic test_random(input int items, input int s_idle, input int r_idle);
      send_idle_pct = s_idle;
      recv_idle_pct = r_idle;
      for (int blk = 0; blk < 3; blk++) begin
         case ($urandom_range(3))
            0: set_env(16'h0000, 9'($urandom_range(511)));
            1: set_env(16'hFFFF, 9'($urandom_range(256)));
            default: set_env(16'($urandom), 9'($urandom));
         endcase
         for (int i = 0; i < items / 3; i++) send_word(rand_freq());
      end
      drain();
   endtask

   // ---------------------------------------------------------------------
   // Response checking
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (level_q.size() == 0) begin
            n_errors++;
            if (n_errors <= 10) $display("unexpected rsp word: noise_db=%0d invalid=%0b",
                                         rsp_noise_db, rsp_invalid);
         end else begin
            level_type lv;
            lv = level_q.pop_front();
            n_checked++;
            if (lv.invalid) n_invalid++;
            if (rsp_noise_db !== lv.noise_db || rsp_invalid !== lv.invalid) begin
               n_errors++;
               if (n_errors <= 10)
                  $display({"mismatch word %0d: noise_db exp %0d got %0d,",
                            " invalid exp %0b got %0b"},
                           n_checked, lv.noise_db, rsp_noise_db, lv.invalid, rsp_invalid);
            end
         end
      end
   end

   // Randomly stall the response side
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Watchdog: count cycles with no accepted word on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) stall_cnt <= 0;
      else stall_cnt <= stall_cnt + 1;
      if (stall_cnt >= STALL_MAX) begin
         $display("** underwater_noise_psd_core: FAILED **");
         $finish;
      end
   end

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_freq_khz  = '0;
      csr_wr_en     = 1'b0;
      csr_index     = '0;
      csr_wdata     = '0;
      cur_wind      = unp_pkg::WIND_RESET;
      cur_ship      = unp_pkg::SHIP_RESET;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      n_sent        = 0;
      n_checked     = 0;
      n_errors      = 0;
      n_invalid     = 0;
      n_cfg         = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random(180, 17, 67);
      test_random(180, 67, 17);
      test_random(180, 0, 0);

      repeat (DRAIN_CYC) @(posedge clock);
      $display("run covered %0d frequency words, %0d checked (%0d flagged invalid), %0d csr writes",
               n_sent, n_checked, n_invalid, n_cfg);
      $display("idle mixes: sender-light/receiver-heavy, reversed, and back-to-back");
      if (n_errors == 0 && level_q.size() == 0) begin
         $display("** underwater_noise_psd_core: PASSED **");
      end else begin
         $display("%0d mismatches, %0d words outstanding", n_errors, level_q.size());
         $display("** underwater_noise_psd_core: FAILED **");
      end
      $finish;
   end

endmodule

@@ underwater_noise_psd_core.f @@
src/unp_pkg.sv
src/unp_delay.sv
src/unp_sqrt.sv
src/unp_log2.sv
src/unp_pow2.sv
src/underwater_noise_psd_core.sv
bench/tb_top.sv
